FILE: design/f2r_pkg.sv
// shared types, constants and the rad50 character map for the filename encoder
// no dependencies; used by f2r_parse and filename_to_rad50_encoder
package f2r_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DEL   = 8'hFF;

	localparam logic [2:0] NAME_MAX = 3'd6;
	localparam logic [2:0] WORD_LEN = 3'd3;
	localparam logic [1:0] EXT_MAX  = 2'd3;

	localparam logic [5:0] CODE_UNKNOWN = 6'd29;

	typedef enum logic [1:0] {
		PH_NAME = 2'd0,
		PH_EXT  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] character;
	} step_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
		logic [15:0] ext;
	} words_t;

	function automatic logic [5:0] rad_code(input logic [7:0] c);
		logic [6:0] l;
		logic [5:0] r;
		l = c[6:0];
		r = CODE_UNKNOWN;
		if (c == CH_DEL) begin
			r = 6'd0;
		end else if (l == 7'h20) begin
			r = 6'd0;
		end else if (l == 7'h24) begin
			r = 6'd27;
		end else if (l == 7'h2E) begin
			r = 6'd28;
		end else if (l >= 7'h30 && l <= 7'h39) begin
			r = 6'd30 + 6'(l - 7'h30);
		end else if (l >= 7'h41 && l <= 7'h5A) begin
			r = 6'd1 + 6'(l - 7'h41);
		end else if (l >= 7'h61 && l <= 7'h7A) begin
			r = 6'd1 + 6'(l - 7'h61);
		end
		return r;
	endfunction

	// weight of a character by its place in a three-character word
	function automatic logic [10:0] weight(input logic [2:0] pos);
		logic [10:0] w;
		case (pos)
			3'd0, 3'd3: w = 11'd1600;
			3'd1, 3'd4: w = 11'd40;
			default:    w = 11'd1;
		endcase
		return w;
	endfunction

endpackage

FILE: design/f2r_parse.sv
// path parser state and rad50 accumulators, one character per step
// depends on f2r_pkg
module f2r_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  f2r_pkg::step_t  step,
	output f2r_pkg::words_t words
);

	f2r_pkg::phase_t phase_q, phase_d;
	logic [2:0]  name_len_q, name_len_d;
	logic [1:0]  ext_len_q, ext_len_d;
	logic [15:0] acc_first_q, acc_first_d;
	logic [15:0] acc_second_q, acc_second_d;
	logic [15:0] acc_ext_q, acc_ext_d;

	logic [5:0]  code;
	logic        is_dot;
	logic [15:0] name_term;
	logic [15:0] ext_term;
	logic        put_name;
	logic        put_ext;

	assign code      = f2r_pkg::rad_code(step.character);
	assign is_dot    = (step.character == f2r_pkg::CH_DOT);
	assign name_term = 16'(f2r_pkg::weight(name_len_q)) * 16'(code);
	assign ext_term  = 16'(f2r_pkg::weight({1'b0, ext_len_q})) * 16'(code);

	always_comb begin
		phase_d      = phase_q;
		put_name     = 1'b0;
		put_ext      = 1'b0;
		name_len_d   = name_len_q;
		ext_len_d    = ext_len_q;
		acc_first_d  = acc_first_q;
		acc_second_d = acc_second_q;
		acc_ext_d    = acc_ext_q;
		if (step.character != f2r_pkg::CH_SLASH) begin
			unique case (phase_q)
				f2r_pkg::PH_NAME: begin
					if (name_len_q == 3'd0) begin
						put_name = 1'b1;
					end else if (is_dot) begin
						phase_d = f2r_pkg::PH_EXT;
					end else if (name_len_q < f2r_pkg::NAME_MAX) begin
						put_name = 1'b1;
					end else begin
						phase_d = f2r_pkg::PH_EXT;
						put_ext = 1'b1;
					end
				end
				f2r_pkg::PH_EXT: begin
					if (ext_len_q == 2'd0) begin
						put_ext = 1'b1;
					end else if (is_dot) begin
						phase_d = f2r_pkg::PH_DONE;
					end else if (ext_len_q < f2r_pkg::EXT_MAX) begin
						put_ext = 1'b1;
					end else begin
						phase_d = f2r_pkg::PH_DONE;
					end
				end
				default: begin
				end
			endcase
			if (put_name) begin
				if (name_len_q < f2r_pkg::WORD_LEN) begin
					acc_first_d = acc_first_q + name_term;
				end else begin
					acc_second_d = acc_second_q + name_term;
				end
				name_len_d = name_len_q + 3'd1;
			end
			if (put_ext) begin
				acc_ext_d = acc_ext_q + ext_term;
				ext_len_d = ext_len_q + 2'd1;
			end
		end else begin
			phase_d      = f2r_pkg::PH_NAME;
			name_len_d   = 3'd0;
			ext_len_d    = 2'd0;
			acc_first_d  = 16'd0;
			acc_second_d = 16'd0;
			acc_ext_d    = 16'd0;
		end
	end

	assign words.first  = acc_first_d;
	assign words.second = acc_second_d;
	assign words.ext    = acc_ext_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= f2r_pkg::PH_NAME;
			name_len_q   <= 3'd0;
			ext_len_q    <= 2'd0;
			acc_first_q  <= 16'd0;
			acc_second_q <= 16'd0;
			acc_ext_q    <= 16'd0;
		end else if (step.valid) begin
			if (step.last) begin
				phase_q      <= f2r_pkg::PH_NAME;
				name_len_q   <= 3'd0;
				ext_len_q    <= 2'd0;
				acc_first_q  <= 16'd0;
				acc_second_q <= 16'd0;
				acc_ext_q    <= 16'd0;
			end else begin
				phase_q      <= phase_d;
				name_len_q   <= name_len_d;
				ext_len_q    <= ext_len_d;
				acc_first_q  <= acc_first_d;
				acc_second_q <= acc_second_d;
				acc_ext_q    <= acc_ext_d;
			end
		end
	end

endmodule

FILE: design/filename_to_rad50_encoder.sv
// top level of the rad50 filename encoder: input register, parser, result register
// depends on f2r_pkg and f2r_parse
//
// Takes a path one character per cycle while req_stall is low and, on the
// character marked is_last, delivers the name and extension as three rad50
// words (name 1-3, name 4-6, extension). Only the part after the latest slash
// counts. A character is registered in the input register, folded into the
// running words by the parser as it leaves that register, and for a last
// character the words then enter the result register, which raises rsp_valid.
// The parser's state update never holds the flow; a request waits only when
// a last character finds an earlier result still stalled in the result
// register.
module filename_to_rad50_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  character,
	input  logic        is_last,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] name_word_first,
	output logic [15:0] name_word_second,
	output logic [15:0] ext_word
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] char_s1;
	logic       advance;
	logic       rsp_valid_q;

	f2r_pkg::step_t  step;
	f2r_pkg::words_t words;
	f2r_pkg::words_t words_q;

	assign advance   = valid_s1 && (!last_s1 || !rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			char_s1 <= character;
			last_s1 <= is_last;
		end
	end

	assign step.valid     = advance;
	assign step.last      = last_s1;
	assign step.character = char_s1;

	f2r_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.words  (words)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			words_q <= words;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign name_word_first  = words_q.first;
	assign name_word_second = words_q.second;
	assign ext_word         = words_q.ext;

	// a new result only follows a last character leaving the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(advance && last_s1))
		else $error("result raised without a last character");

	// a last character never overwrites a result that is still stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |-> (!rsp_valid_q || !rsp_stall))
		else $error("pending result overwritten");

	// requests wait only behind a last character blocked by the result side
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && last_s1 && rsp_valid_q && rsp_stall))
		else $error("request stalled without cause");

endmodule

FILE: verif/tb_filename_to_rad50_encoder.sv
// testbench for filename_to_rad50_encoder: sends paths one character per request and
// checks each triple of rad50 words against an in-bench path parser
// depends on f2r_pkg and the encoder rtl
`timescale 1ns / 100ps

module tb_filename_to_rad50_encoder;

	typedef logic [7:0] byte_q_t[$];

	localparam int TOTAL_CHARS = 1100;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_SHOWN   = 10;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [7:0]  character;
	logic        is_last;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [15:0] name_word_first;
	logic [15:0] name_word_second;
	logic [15:0] ext_word;

	// running state of the path being parsed
	f2r_pkg::phase_t phase;
	logic [2:0]  name_len;
	logic [1:0]  ext_len;
	logic [15:0] acc_first;
	logic [15:0] acc_second;
	logic [15:0] acc_ext;

	f2r_pkg::words_t pending_words[$];
	f2r_pkg::words_t head_words;

	int          errors;
	int          chars_sent;
	int          paths_sent;
	int          words_checked;
	int          stuck;
	int          hold_left;
	bit          steady;

	filename_to_rad50_encoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.character(character),
		.is_last(is_last),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.name_word_first(name_word_first),
		.name_word_second(name_word_second),
		.ext_word(ext_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [5:0] char_to_rad50(input logic [7:0] b);
		logic [6:0] low;
		logic [6:0] folded;
		low = b[6:0];
		folded = low | 7'h20;
		if (b == 8'hFF || low == 7'h20)
			return 6'd0;
		if (low == 7'h24)
			return 6'd27;
		if (low == 7'h2E)
			return 6'd28;
		if (low >= 7'h30 && low <= 7'h39)
			return 6'd30 + 6'(low - 7'h30);
		if (folded >= 7'h61 && folded <= 7'h7A)
			return 6'd1 + 6'(folded - 7'h61);
		return 6'd29;
	endfunction

	function automatic logic [15:0] place_weight(input int pos);
		case (pos % 3)
			0: return 16'd1600;
			1: return 16'd40;
			default: return 16'd1;
		endcase
	endfunction

	task automatic clear_path();
		phase = f2r_pkg::PH_NAME;
		name_len = 3'd0;
		ext_len = 2'd0;
		acc_first = 16'd0;
		acc_second = 16'd0;
		acc_ext = 16'd0;
	endtask

	task automatic add_name(input logic [5:0] code);
		if (name_len < 3'd3)
			acc_first = acc_first + 16'(place_weight(name_len) * code);
		else
			acc_second = acc_second + 16'(place_weight(name_len) * code);
		name_len = name_len + 3'd1;
	endtask

	task automatic add_ext(input logic [5:0] code);
		acc_ext = acc_ext + 16'(place_weight(ext_len) * code);
		ext_len = ext_len + 2'd1;
	endtask

	task automatic parse_char(input logic [7:0] ch, input logic last);
		logic [5:0] code;
		code = char_to_rad50(ch);
		if (ch == f2r_pkg::CH_SLASH) begin
			clear_path();
		end else begin
			case (phase)
				f2r_pkg::PH_NAME: begin
					if (name_len == 3'd0)
						add_name(code);
					else if (ch == f2r_pkg::CH_DOT)
						phase = f2r_pkg::PH_EXT;
					else if (name_len < f2r_pkg::NAME_MAX)
						add_name(code);
					else begin
						phase = f2r_pkg::PH_EXT;
						add_ext(code);
					end
				end
				f2r_pkg::PH_EXT: begin
					if (ext_len == 2'd0)
						add_ext(code);
					else if (ch == f2r_pkg::CH_DOT)
						phase = f2r_pkg::PH_DONE;
					else if (ext_len < f2r_pkg::EXT_MAX)
						add_ext(code);
					else
						phase = f2r_pkg::PH_DONE;
				end
				default: ;
			endcase
		end
		if (last) begin
			pending_words.push_back('{first: acc_first, second: acc_second, ext: acc_ext});
			paths_sent++;
			clear_path();
		end
	endtask

	task automatic note_error(input string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("mismatch: %s", msg);
	endtask

	task automatic send_char(input logic [7:0] ch, input logic last);
		int gap;
		@(negedge clk);
		if (!steady && $urandom_range(99) < 9) begin
			req_valid <= 1'b0;
			gap = $urandom_range(3, 1);
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		character <= ch;
		is_last <= last;
		do @(posedge clk); while (req_stall);
		chars_sent++;
		parse_char(ch, last);
	endtask

	task automatic send_seq(input byte_q_t p);
		foreach (p[i])
			send_char(p[i], i == p.size() - 1);
	endtask

	task automatic send_path(input string s);
		byte_q_t p;
		for (int i = 0; i < s.len(); i++)
			p.push_back(s[i]);
		send_seq(p);
	endtask

	task automatic pause_sender();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 35) return 8'($urandom_range(8'h5A, 8'h41));
		if (r < 55) return 8'($urandom_range(8'h7A, 8'h61));
		if (r < 70) return 8'($urandom_range(8'h39, 8'h30));
		if (r < 74) return 8'h24;
		if (r < 78) return 8'h20;
		if (r < 88) return 8'($urandom_range(255, 128));
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic build_path(output byte_q_t p);
		int kind;
		int dirs;
		kind = $urandom_range(99);
		p = {};
		if (kind < 15) begin
			repeat ($urandom_range(12, 1))
				p.push_back(8'($urandom_range(255, 1)));
		end else begin
			dirs = ($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0;
			repeat (dirs) begin
				repeat ($urandom_range(4, 1))
					p.push_back(pick_char());
				p.push_back(f2r_pkg::CH_SLASH);
			end
			repeat ($urandom_range(8, 1))
				p.push_back(pick_char());
			if ($urandom_range(9) < 7) begin
				p.push_back(f2r_pkg::CH_DOT);
				repeat ($urandom_range(4, 0))
					p.push_back(pick_char());
				if ($urandom_range(9) == 0) begin
					p.push_back(f2r_pkg::CH_DOT);
					p.push_back(pick_char());
				end
			end
			if (kind < 25)
				p[$urandom_range(p.size() - 1, 0)] =
					$urandom_range(1) ? f2r_pkg::CH_DOT : f2r_pkg::CH_SLASH;
		end
	endtask

	task automatic test_directed_paths();
		send_path("A");
		send_path("ABC");
		send_path("abcdef.txt");
		send_path("999999.999");
		send_path(".login");
		send_path("a..b");
		send_path("abcdefg");
		send_path("abcdefghij");
		send_path("abcdef.xyz");
		send_path("a.b.c");
		send_path("a.bcdef");
		send_path("usr/lib/x.c");
		send_path("abc/");
		send_path("/");
		send_path("//$ 09.Z z");
		send_seq('{8'hC1, 8'hAE, 8'hAF, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hE1, 8'hFE});
	endtask

	task automatic test_random_paths(input int until_chars);
		byte_q_t p;
		while (chars_sent < until_chars) begin
			build_path(p);
			send_seq(p);
		end
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		test_random_paths(chars_sent + 150);
		steady = 1'b0;
	endtask

	task automatic test_receiver_hold();
		hold_left = HOLD_CYCLES;
		repeat (30)
			send_char(pick_char(), 1'b1);
		send_path("hold.end");
	endtask

	task automatic test_drain_pause();
		send_path("pre.drn");
		pause_sender();
		while (pending_words.size() > 0)
			@(posedge clk);
		send_path("post.drn");
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_words.size() == 0) begin
				note_error($sformatf("unexpected words %0d %0d %0d",
					name_word_first, name_word_second, ext_word));
			end else begin
				head_words = pending_words.pop_front();
				words_checked++;
				if (name_word_first !== head_words.first)
					note_error($sformatf("name_word_first exp %0d got %0d",
						head_words.first, name_word_first));
				if (name_word_second !== head_words.second)
					note_error($sformatf("name_word_second exp %0d got %0d",
						head_words.second, name_word_second));
				if (ext_word !== head_words.ext)
					note_error($sformatf("ext_word exp %0d got %0d",
						head_words.ext, ext_word));
			end
		end
	end

	// receiver stall
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (steady)
				rsp_stall <= 1'b0;
			else
				rsp_stall <= ($urandom_range(99) < 9);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		character = 8'h41;
		is_last = 1'b0;
		steady = 1'b0;
		hold_left = 0;
		errors = 0;
		chars_sent = 0;
		paths_sent = 0;
		words_checked = 0;
		stuck = 0;
		clear_path();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_paths();
		test_random_paths(450);
		test_steady_stream();
		test_receiver_hold();
		test_drain_pause();
		test_random_paths(TOTAL_CHARS);

		pause_sender();
		while (pending_words.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d characters in %0d paths, checked %0d word triples",
			chars_sent, paths_sent, words_checked);
		$display("included receiver hold, sender drain pause and a stall-free stretch");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
design/f2r_pkg.sv
design/f2r_parse.sv
design/filename_to_rad50_encoder.sv
verif/tb_filename_to_rad50_encoder.sv
